/* hw/rtl/utf8_stream_decoder_assert.svh */
// Assertion macros for the decoder checker.
`ifndef UTF8_STREAM_DECODER_ASSERT_SVH
`define UTF8_STREAM_DECODER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define U8D_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("utf8 decoder assertion failed");

// Next-cycle implication.
`define U8D_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("utf8 decoder assertion failed");

`endif

/* hw/rtl/u8dec_pkg.sv */
// Types, constants and lead-byte decode for the UTF-8 stream decoder.
`default_nettype none

package u8dec_pkg;

  localparam logic [20:0] REPLACEMENT_CP = 21'h00FFFD;
  localparam logic [20:0] CP_MAX         = 21'h10FFFF;
  localparam logic [20:0] MIN_CP_LEN2    = 21'h000080;
  localparam logic [20:0] MIN_CP_LEN3    = 21'h000800;
  localparam logic [20:0] MIN_CP_LEN4    = 21'h010000;
  localparam logic [20:0] SURROGATE_LO   = 21'h00D800;
  localparam logic [20:0] SURROGATE_HI   = 21'h00DFFF;
  localparam logic [7:0]  LEAD_MIN       = 8'hC2;
  localparam logic [7:0]  LEAD_MAX       = 8'hF4;
  localparam logic [7:0]  CONT_MASK      = 8'hC0;
  localparam logic [7:0]  CONT_TAG       = 8'h80;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_buffer;
  } in_req_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic        malformed;
    logic        run_end;
  } out_req_t;

  // Outcome of reading a byte as the start of a new sequence.
  typedef struct packed {
    logic        emit;
    logic [20:0] cp;
    logic        bad;
    logic [2:0]  len;
    logic [20:0] val;
  } lead_t;

  function automatic lead_t decode_lead(input logic [7:0] b, input logic eob);
    lead_t r;
    r      = '0;
    r.cp   = REPLACEMENT_CP;
    r.bad  = 1'b1;
    if (!b[7]) begin
      r.emit = 1'b1;
      r.cp   = {13'd0, b};
      r.bad  = 1'b0;
    end else if (b < LEAD_MIN || b > LEAD_MAX) begin
      r.emit = 1'b1;
    end else if (eob) begin
      r.emit = 1'b1;
    end else begin
      priority if (b < 8'hE0) begin
        r.len = 3'd2;
        r.val = {16'd0, b[4:0]};
      end else if (b < 8'hF0) begin
        r.len = 3'd3;
        r.val = {17'd0, b[3:0]};
      end else begin
        r.len = 3'd4;
        r.val = {18'd0, b[2:0]};
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/utf8_stream_decoder.sv */
// UTF-8 stream decoder: bytes in, scalar values or U+FFFD replacements out.
//
// Takes one byte per cycle while in_stall_o is low. A byte sits in an input
// register, is decoded against the open-sequence state and loaded into the result
// register as a burst of up to four results: some U+FFFD errors followed by an
// optional final result. The result port shows one result per cycle while
// out_stall_i is low, so a byte that yields several results occupies the result
// register until its last result is taken and holds back the input until then;
// bytes that yield zero or one result flow at one per cycle when not stalled.
// run_end marks the last result of each byte.
`default_nettype none

module utf8_stream_decoder
  import u8dec_pkg::*;
(
  input  wire      clk_i,
  input  wire      rst_ni,
  input  wire      in_valid_i,
  output logic     in_stall_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  wire      out_stall_i,
  output out_req_t out_req_o
);

  // Input register.
  logic    in_valid_q;
  in_req_t in_req_q;

  // Open-sequence state.
  logic [20:0] pv_q, pv_d;
  logic [2:0]  len_q, len_d;
  logic [1:0]  seen_q, seen_d;

  // Result burst: pending error count, then an optional final result.
  logic [2:0]  err_q, err_d;
  logic        tail_valid_q, tail_valid_d;
  logic [20:0] tail_cp_q, tail_cp_d;
  logic        tail_bad_q, tail_bad_d;

  logic out_fire, burst_last, burst_free, advance;

  // Decode results.
  lead_t       lead;
  logic        seq_open, is_cont, complete, range_bad;
  logic [2:0]  seen_n;
  logic [20:0] val_n, min_cp;
  logic [2:0]  n_err;
  logic        n_tail;
  logic [20:0] n_tail_cp;
  logic        n_tail_bad;

  assign out_valid_o = (err_q != 3'd0) || tail_valid_q;
  assign out_fire    = out_valid_o && !out_stall_i;
  assign burst_last  = (err_q == 3'd1 && !tail_valid_q) || (err_q == 3'd0 && tail_valid_q);
  assign burst_free  = !out_valid_o || (burst_last && out_fire);
  assign advance     = in_valid_q && burst_free;
  assign in_stall_o  = in_valid_q && !burst_free;

  always_comb begin
    out_req_o.code_point = tail_cp_q;
    out_req_o.malformed  = tail_bad_q;
    out_req_o.run_end    = 1'b1;
    if (err_q != 3'd0) begin
      out_req_o.code_point = REPLACEMENT_CP;
      out_req_o.malformed  = 1'b1;
      out_req_o.run_end    = (err_q == 3'd1) && !tail_valid_q;
    end
  end

  always_comb begin
    lead      = decode_lead(in_req_q.in_byte, in_req_q.end_of_buffer);
    seq_open  = (len_q != 3'd0);
    is_cont   = (in_req_q.in_byte & CONT_MASK) == CONT_TAG;
    seen_n    = {1'b0, seen_q} + 3'd1;
    val_n     = {pv_q[14:0], in_req_q.in_byte[5:0]};
    complete  = (seen_n + 3'd1) == len_q;
    priority if (len_q == 3'd2) begin
      min_cp = MIN_CP_LEN2;
    end else if (len_q == 3'd3) begin
      min_cp = MIN_CP_LEN3;
    end else begin
      min_cp = MIN_CP_LEN4;
    end
    range_bad = (val_n < min_cp) || (val_n > CP_MAX) ||
                (val_n >= SURROGATE_LO && val_n <= SURROGATE_HI);

    n_err      = 3'd0;
    n_tail     = lead.emit;
    n_tail_cp  = lead.cp;
    n_tail_bad = lead.bad;
    pv_d       = lead.val;
    len_d      = lead.len;
    seen_d     = 2'd0;

    if (seq_open && !is_cont) begin
      // Drop the lead, flag each taken continuation, re-read this byte as a lead.
      n_err = 3'd1 + {1'b0, seen_q};
    end else if (seq_open) begin
      n_tail    = 1'b0;
      n_tail_cp = val_n;
      pv_d      = '0;
      len_d     = 3'd0;
      if (complete) begin
        if (range_bad) begin
          n_err = 3'd1 + seen_n;
        end else begin
          n_tail     = 1'b1;
          n_tail_bad = 1'b0;
        end
      end else if (in_req_q.end_of_buffer) begin
        n_err = 3'd1 + seen_n;
      end else begin
        // Hold the sequence open and advance.
        pv_d   = val_n;
        len_d  = len_q;
        seen_d = seen_n[1:0];
      end
    end
  end

  always_comb begin
    err_d        = err_q;
    tail_valid_d = tail_valid_q;
    tail_cp_d    = tail_cp_q;
    tail_bad_d   = tail_bad_q;
    if (advance) begin
      err_d        = n_err;
      tail_valid_d = n_tail;
      tail_cp_d    = n_tail_cp;
      tail_bad_d   = n_tail_bad;
    end else if (out_fire) begin
      if (err_q != 3'd0) begin
        err_d = err_q - 3'd1;
      end else begin
        tail_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      pv_q         <= '0;
      len_q        <= '0;
      seen_q       <= '0;
      err_q        <= '0;
      tail_valid_q <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        pv_q   <= pv_d;
        len_q  <= len_d;
        seen_q <= seen_d;
      end
      err_q        <= err_d;
      tail_valid_q <= tail_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_req_q <= in_req_i;
    end
    tail_cp_q  <= tail_cp_d;
    tail_bad_q <= tail_bad_d;
  end

endmodule

`default_nettype wire

/* hw/rtl/u8dec_checker.sv */
// Port-level checker for the UTF-8 stream decoder, bound to the top level.
`default_nettype none

`include "utf8_stream_decoder_assert.svh"

module u8dec_checker
  import u8dec_pkg::*;
(
  input wire      clk_i,
  input wire      rst_ni,
  input wire      out_valid_o,
  input wire      out_stall_i,
  input out_req_t out_req_o
);

  logic is_repl, is_scalar;

  assign is_repl   = out_req_o.code_point == REPLACEMENT_CP;
  assign is_scalar = out_req_o.code_point <= CP_MAX &&
                     (out_req_o.code_point < SURROGATE_LO ||
                      out_req_o.code_point > SURROGATE_HI);

  `U8D_ASSERT_NOW(a_bad_is_repl, out_valid_o && out_req_o.malformed, is_repl)
  `U8D_ASSERT_NOW(a_good_is_scalar, out_valid_o && !out_req_o.malformed, is_scalar)
  `U8D_ASSERT_NOW(a_good_ends_run, out_valid_o && !out_req_o.malformed, out_req_o.run_end)
  `U8D_ASSERT_NEXT(a_stall_holds, out_valid_o && out_stall_i, out_valid_o && $stable(out_req_o))

endmodule

bind utf8_stream_decoder u8dec_checker u_checker (.*);

`default_nettype wire
